### rtl/ssc_pkg.sv
package ssc_pkg;

    localparam int ANGLE_W = 9;
    localparam int DUTY_W = 12;
    localparam int LIMIT_W = 8;
    localparam int OFFSET_W = 7;
    localparam int CFG_ADDR_W = 3;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic [DUTY_W-1:0] t_duty;

    localparam logic [3:0] CMD_TICK        = 4'd0;
    localparam logic [3:0] CMD_SET_ALL     = 4'd1;
    localparam logic [3:0] CMD_SET_ONE     = 4'd2;
    localparam logic [3:0] CMD_SET_TWO     = 4'd3;
    localparam logic [3:0] CMD_SET_THREE   = 4'd4;
    localparam logic [3:0] CMD_SET12       = 4'd5;
    localparam logic [3:0] CMD_SET12_INV   = 4'd6;
    localparam logic [3:0] CMD_BOUNCE_ONE  = 4'd7;
    localparam logic [3:0] CMD_BOUNCE_TWO  = 4'd8;
    localparam logic [3:0] CMD_BOUNCE_THREE = 4'd9;
    localparam logic [3:0] CMD_STOP        = 4'd10;

    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_ONE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_TWO  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_THREE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_PAIR    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_PAIR   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THIRD   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THIRD  = 3'd6;

    localparam logic signed [OFFSET_W-1:0] OFFSET_ONE_RST   = 7'sd5;
    localparam logic signed [OFFSET_W-1:0] OFFSET_TWO_RST   = -7'sd5;
    localparam logic signed [OFFSET_W-1:0] OFFSET_THREE_RST = 7'sd0;
    localparam logic [LIMIT_W-1:0] LOW_PAIR_RST   = 8'd10;
    localparam logic [LIMIT_W-1:0] HIGH_PAIR_RST  = 8'd170;
    localparam logic [LIMIT_W-1:0] LOW_THIRD_RST  = 8'd60;
    localparam logic [LIMIT_W-1:0] HIGH_THIRD_RST = 8'd120;

    localparam t_angle ANGLE_RST = 9'sd90;
    localparam logic [LIMIT_W-1:0] MIRROR_ANGLE = 8'd180;

    localparam logic signed [12:0] DUTY_BASE = 13'sd625;
    localparam logic signed [12:0] DUTY_TOP = 13'sd3125;
    // angle * 2500 / 270 is angle * 250 / 27; 19418250 / 2^21 approximates 250 / 27, exact
    // after truncation for every magnitude up to 256.
    localparam logic [24:0] DUTY_RECIP = 25'd19418250;
    localparam int DUTY_SHIFT = 21;

    typedef struct packed {
        logic set_en;
        logic mirror;
        logic bounce_en;
        logic stop_en;
        logic tick_en;
    } t_motor_ctl;

    typedef struct packed {
        logic [LIMIT_W-1:0] lo;
        logic [LIMIT_W-1:0] hi;
        logic signed [OFFSET_W-1:0] off;
    } t_motor_cfg;

    function automatic t_angle sat9(input logic signed [10:0] x);
        t_angle y;
        if (x > 11'sd255) begin
            y = 9'sd255;
        end else if (x < -11'sd256) begin
            y = -9'sd256;
        end else begin
            y = x[8:0];
        end
        return y;
    endfunction

endpackage

### rtl/ssc_motor.sv
module ssc_motor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssc_pkg::t_motor_ctl  i_ctl,
    input  ssc_pkg::t_motor_cfg  i_cfg,
    input  logic [7:0]           i_value,
    output ssc_pkg::t_angle      o_angle
);

    ssc_pkg::t_angle r_cur, n_cur;
    ssc_pkg::t_angle r_tgt, n_tgt;
    logic r_bounce, n_bounce;

    logic signed [10:0] off_x;
    logic signed [10:0] lo_o;
    logic signed [10:0] hi_o;
    logic signed [10:0] cur_x;
    logic [7:0] clamped;
    logic signed [10:0] set_sum;
    ssc_pkg::t_angle tick_tgt;

    always_comb begin
        off_x = {{4{i_cfg.off[6]}}, i_cfg.off};
        lo_o = $signed({3'b000, i_cfg.lo}) + off_x;
        hi_o = $signed({3'b000, i_cfg.hi}) + off_x;
        cur_x = {{2{r_cur[8]}}, r_cur};
        if (i_value > i_cfg.hi) begin
            clamped = i_cfg.hi;
        end else if (i_value < i_cfg.lo) begin
            clamped = i_cfg.lo;
        end else begin
            clamped = i_value;
        end
        if (i_ctl.mirror) begin
            set_sum = $signed({3'b000, ssc_pkg::MIRROR_ANGLE}) - $signed({3'b000, clamped})
                      + off_x;
        end else begin
            set_sum = $signed({3'b000, clamped}) + off_x;
        end
    end

    always_comb begin
        n_cur = r_cur;
        n_tgt = r_tgt;
        n_bounce = r_bounce;
        tick_tgt = r_tgt;
        if (r_bounce) begin
            if (cur_x >= hi_o) begin
                tick_tgt = ssc_pkg::sat9(lo_o);
            end else if (cur_x <= lo_o) begin
                tick_tgt = ssc_pkg::sat9(hi_o);
            end
        end
        priority if (i_ctl.set_en) begin
            n_tgt = ssc_pkg::sat9(set_sum);
            n_bounce = 1'b0;
        end else if (i_ctl.bounce_en) begin
            n_bounce = 1'b1;
            n_tgt = ssc_pkg::sat9((cur_x >= hi_o) ? lo_o : hi_o);
        end else if (i_ctl.stop_en) begin
            n_bounce = 1'b0;
        end else if (i_ctl.tick_en) begin
            n_tgt = tick_tgt;
            if (r_cur < tick_tgt) begin
                n_cur = r_cur + 9'sd1;
            end else if (r_cur > tick_tgt) begin
                n_cur = r_cur - 9'sd1;
            end
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= ssc_pkg::ANGLE_RST;
            r_tgt <= ssc_pkg::ANGLE_RST;
            r_bounce <= 1'b0;
        end else begin
            r_cur <= n_cur;
            r_tgt <= n_tgt;
            r_bounce <= n_bounce;
        end
    end

    assign o_angle = r_cur;

endmodule

### rtl/ssc_duty.sv
module ssc_duty (
    input  ssc_pkg::t_angle i_angle,
    output ssc_pkg::t_duty  o_duty
);

    logic [9:0] mag;
    logic [34:0] prod;
    logic [11:0] quot;
    logic signed [12:0] level;

    always_comb begin
        mag = i_angle[8] ? 10'(-{i_angle[8], i_angle}) : {1'b0, i_angle};
        prod = 35'(mag) * 35'(ssc_pkg::DUTY_RECIP);
        quot = prod[ssc_pkg::DUTY_SHIFT +: 12];
        if (i_angle[8]) begin
            level = ssc_pkg::DUTY_BASE - $signed({1'b0, quot});
        end else begin
            level = ssc_pkg::DUTY_BASE + $signed({1'b0, quot});
        end
        if (level < 13'sd0) begin
            o_duty = '0;
        end else if (level > ssc_pkg::DUTY_TOP) begin
            o_duty = ssc_pkg::DUTY_TOP[11:0];
        end else begin
            o_duty = level[11:0];
        end
    end

endmodule

### rtl/three_servo_slew_controller.sv
// Three-servo slew controller. Each input word carries a command and an angle;
// a tick moves every servo angle one degree toward its target unless motion is
// stopped, and the other commands set targets, start bounce mode or stop. Every
// accepted word yields exactly one output word with the pulse level of each
// servo and the stopped flag. One word is accepted per clock cycle when the
// output side keeps up; each result passes through the input register, the
// servo state update and the output register that holds the pulse levels. A
// stalled output holds the stages behind it, so at most three words are inside
// at once. Configuration writes take effect on the next clock edge and must
// only occur while the block is idle.
module three_servo_slew_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // command [3:0], value [11:4], zeros above
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // duty_one, duty_two, duty_three, halted, zeros
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    logic r_in_valid;
    logic [3:0] r_in_cmd;
    logic [7:0] r_in_value;
    logic r_u_valid;
    logic r_o_valid;
    ssc_pkg::t_duty r_o_duty [3];
    logic r_o_halted;
    logic r_stopped, n_stopped;

    logic signed [6:0] r_off [3];
    logic [7:0] r_lo_pair, r_hi_pair, r_lo_third, r_hi_third;

    logic out_free, u_adv, u_free, in_adv, in_fire;
    logic value_ok;
    ssc_pkg::t_motor_ctl ctl [3];
    ssc_pkg::t_motor_cfg mcfg [3];
    ssc_pkg::t_angle angle [3];
    ssc_pkg::t_duty duty [3];

    assign out_free = !r_o_valid || m_axis_tready;
    assign u_adv = r_u_valid && out_free;
    assign u_free = !r_u_valid || out_free;
    assign in_adv = r_in_valid && u_free;
    assign s_axis_tready = !r_in_valid || u_free;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign value_ok = r_in_value <= ssc_pkg::MIRROR_ANGLE;

    always_comb begin
        for (int m = 0; m < 3; m++) begin
            ctl[m] = '0;
        end
        n_stopped = r_stopped;
        if (in_adv) begin
            unique case (r_in_cmd)
                ssc_pkg::CMD_TICK: begin
                    for (int m = 0; m < 3; m++) begin
                        ctl[m].tick_en = !r_stopped;
                    end
                end
                ssc_pkg::CMD_SET_ALL: begin
                    if (value_ok) begin
                        for (int m = 0; m < 3; m++) begin
                            ctl[m].set_en = 1'b1;
                        end
                        ctl[1].mirror = 1'b1;
                        n_stopped = 1'b0;
                    end
                end
                ssc_pkg::CMD_SET_ONE: begin
                    if (value_ok) begin
                        ctl[0].set_en = 1'b1;
                        n_stopped = 1'b0;
                    end
                end
                ssc_pkg::CMD_SET_TWO: begin
                    if (value_ok) begin
                        ctl[1].set_en = 1'b1;
                        ctl[1].mirror = 1'b1;
                        n_stopped = 1'b0;
                    end
                end
                ssc_pkg::CMD_SET_THREE: begin
                    if (value_ok) begin
                        ctl[2].set_en = 1'b1;
                        n_stopped = 1'b0;
                    end
                end
                ssc_pkg::CMD_SET12, ssc_pkg::CMD_SET12_INV: begin
                    if (value_ok) begin
                        ctl[0].set_en = 1'b1;
                        ctl[1].set_en = 1'b1;
                        ctl[1].mirror = (r_in_cmd == ssc_pkg::CMD_SET12);
                        n_stopped = 1'b0;
                    end
                end
                ssc_pkg::CMD_BOUNCE_ONE: begin
                    ctl[0].bounce_en = 1'b1;
                    n_stopped = 1'b0;
                end
                ssc_pkg::CMD_BOUNCE_TWO: begin
                    ctl[1].bounce_en = 1'b1;
                    n_stopped = 1'b0;
                end
                ssc_pkg::CMD_BOUNCE_THREE: begin
                    ctl[2].bounce_en = 1'b1;
                    n_stopped = 1'b0;
                end
                ssc_pkg::CMD_STOP: begin
                    for (int m = 0; m < 3; m++) begin
                        ctl[m].stop_en = 1'b1;
                    end
                    n_stopped = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign mcfg[0] = '{lo: r_lo_pair, hi: r_hi_pair, off: r_off[0]};
    assign mcfg[1] = '{lo: r_lo_pair, hi: r_hi_pair, off: r_off[1]};
    assign mcfg[2] = '{lo: r_lo_third, hi: r_hi_third, off: r_off[2]};

    for (genvar m = 0; m < 3; m++) begin : g_motor
        ssc_motor u_motor (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[m]),
            .i_cfg   (mcfg[m]),
            .i_value (r_in_value),
            .o_angle (angle[m])
        );

        ssc_duty u_duty (
            .i_angle (angle[m]),
            .o_duty  (duty[m])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_u_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_stopped <= 1'b0;
            r_off[0] <= ssc_pkg::OFFSET_ONE_RST;
            r_off[1] <= ssc_pkg::OFFSET_TWO_RST;
            r_off[2] <= ssc_pkg::OFFSET_THREE_RST;
            r_lo_pair <= ssc_pkg::LOW_PAIR_RST;
            r_hi_pair <= ssc_pkg::HIGH_PAIR_RST;
            r_lo_third <= ssc_pkg::LOW_THIRD_RST;
            r_hi_third <= ssc_pkg::HIGH_THIRD_RST;
        end else begin
            r_in_valid <= in_fire || (r_in_valid && !in_adv);
            r_u_valid <= in_adv || (r_u_valid && !u_adv);
            r_o_valid <= u_adv || (r_o_valid && !m_axis_tready);
            r_stopped <= n_stopped;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    ssc_pkg::REG_OFFSET_ONE:   r_off[0] <= i_cfg_wdata[6:0];
                    ssc_pkg::REG_OFFSET_TWO:   r_off[1] <= i_cfg_wdata[6:0];
                    ssc_pkg::REG_OFFSET_THREE: r_off[2] <= i_cfg_wdata[6:0];
                    ssc_pkg::REG_LOW_PAIR:     r_lo_pair <= i_cfg_wdata;
                    ssc_pkg::REG_HIGH_PAIR:    r_hi_pair <= i_cfg_wdata;
                    ssc_pkg::REG_LOW_THIRD:    r_lo_third <= i_cfg_wdata;
                    ssc_pkg::REG_HIGH_THIRD:   r_hi_third <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_cmd <= s_axis_tdata[3:0];
            r_in_value <= s_axis_tdata[11:4];
        end
        if (u_adv) begin
            r_o_duty[0] <= duty[0];
            r_o_duty[1] <= duty[1];
            r_o_duty[2] <= duty[2];
            r_o_halted <= r_stopped;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata = {3'b000, r_o_halted, r_o_duty[2], r_o_duty[1], r_o_duty[0]};

endmodule

### rtl/ssc_checker.sv
module ssc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // After reset the block holds no word and can take one.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("output valid or input not ready after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed or dropped");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:0] <= 12'd3125 && m_axis_tdata[23:12] <= 12'd3125
                           && m_axis_tdata[35:24] <= 12'd3125 && m_axis_tdata[39:37] == 3'b000))
        else $error("pulse level out of range or padding not zero");

    // The input side only waits while an output word is held by the consumer.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled output word");

endmodule

bind three_servo_slew_controller ssc_checker u_ssc_checker (.*);
